// ----- sv/ptsb_pkg.sv -----
// Package for the periodic timer slot bank: codes, limits and shared structs.
package ptsb_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int MAX_RESULTS    = 8;
    localparam int PERIOD_W       = 16;
    localparam int TIME_W         = 32;

    // input item kinds
    localparam logic [1:0] K_TICK    = 2'd0;
    localparam logic [1:0] K_REQUEST = 2'd1;
    localparam logic [1:0] K_RELEASE = 2'd2;
    localparam logic [1:0] K_SET     = 2'd3;

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_REFUSED = 2'd1,
        ST_FIRED   = 2'd2,
        ST_DONE    = 2'd3
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [2:0]          slot_number;
        logic [TIME_W-1:0]   time_now;
        logic                last;
    } t_result;

    typedef struct packed {
        logic                en;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] remaining;
    } t_slot_wr;

    typedef struct packed {
        logic                active;
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] remaining;
    } t_slot_rd;

endpackage

// ----- sv/ptsb_slot_mem.sv -----
// Slot store: period/remaining memory with registered read, plus per-slot active bits.
module ptsb_slot_mem #(
    parameter int SLOT_COUNT = 8,
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [IW-1:0]      i_rd_addr,
    output logic               o_act,
    output ptsb_pkg::t_slot_rd o_rd,
    input  logic [IW-1:0]      i_wr_addr,
    input  ptsb_pkg::t_slot_wr i_wr
);
    import ptsb_pkg::*;

    logic [SLOT_COUNT-1:0]      r_active;
    logic [2*PERIOD_W-1:0]      r_mem [SLOT_COUNT];
    logic [2*PERIOD_W-1:0]      r_rd_word;
    logic                       r_rd_act;

    // active bit doubles as valid bit: an inactive slot reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_wr.en) begin
            r_active[i_wr_addr] <= (i_wr.period != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= {i_wr.period, i_wr.remaining};
        end
        r_rd_word <= r_mem[i_rd_addr];
        r_rd_act  <= r_active[i_rd_addr];
    end

    assign o_act          = r_active[i_rd_addr];
    assign o_rd.active    = r_rd_act;
    assign o_rd.period    = r_rd_act ? r_rd_word[2*PERIOD_W-1:PERIOD_W] : '0;
    assign o_rd.remaining = r_rd_act ? r_rd_word[PERIOD_W-1:0] : '0;

endmodule

// ----- sv/ptsb_seq.sv -----
// Sequencer: walks the slots one at a time with a shared decrement/compare unit.
module ptsb_seq #(
    parameter int SLOT_COUNT = 8,
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic [2:0]         i_slot,
    input  logic [15:0]        i_period,
    output logic [IW-1:0]      o_addr,
    input  logic               i_act,
    input  ptsb_pkg::t_slot_rd i_rd,
    output logic [IW-1:0]      o_wr_addr,
    output ptsb_pkg::t_slot_wr o_wr,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output ptsb_pkg::t_result  o_res
);
    import ptsb_pkg::*;

    localparam int CW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_TREAD  = 6'b000100,
        S_TEVAL  = 6'b001000,
        S_FLUSH  = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state              r_state, n_state;
    logic [IW-1:0]       r_idx, n_idx;
    logic [TIME_W-1:0]   r_tick, n_tick;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_pend_v, n_pend_v;
    logic [2:0]          r_pend_slot, n_pend_slot;
    t_status             r_st, n_st;
    logic [2:0]          r_res_slot, n_res_slot;
    logic [PERIOD_W-1:0] r_period, n_period;

    logic [IW+2:0]       wide_slot;
    logic [IW+2:0]       wide_idx;
    logic                slot_ok;
    logic                last_idx;
    logic [PERIOD_W-1:0] dec;
    logic                fire;
    logic                report;
    logic                stall;

    assign wide_slot = (IW+3)'(i_slot);
    assign wide_idx  = (IW+3)'(r_idx);
    assign slot_ok   = wide_slot < (IW+3)'(SLOT_COUNT);
    assign last_idx  = (r_idx == IW'(SLOT_COUNT - 1));
    assign dec       = i_rd.remaining - PERIOD_W'(1);
    assign fire      = i_rd.active && (dec == '0);
    assign report    = fire && (r_cnt < CW'(MAX_RESULTS));
    // a new firing pushes out the previous one, which is then known not to be last
    assign stall     = report && r_pend_v && !i_res_ready;

    assign o_addr  = r_idx;
    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_tick      = r_tick;
        n_cnt       = r_cnt;
        n_pend_v    = r_pend_v;
        n_pend_slot = r_pend_slot;
        n_st        = r_st;
        n_res_slot  = r_res_slot;
        n_period    = r_period;
        o_wr_addr   = r_idx;
        o_wr        = '0;
        o_res_valid = 1'b0;
        o_res       = '{status: r_st, slot_number: r_res_slot, time_now: r_tick, last: 1'b1};

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_kind)
                        K_TICK: begin
                            n_tick   = r_tick + TIME_W'(1);
                            n_idx    = '0;
                            n_cnt    = '0;
                            n_pend_v = 1'b0;
                            n_state  = S_TREAD;
                        end
                        K_REQUEST: begin
                            if (i_period == '0) begin
                                n_st       = ST_REFUSED;
                                n_res_slot = '0;
                                n_state    = S_EMIT;
                            end else begin
                                n_idx    = '0;
                                n_period = i_period;
                                n_state  = S_SEARCH;
                            end
                        end
                        K_RELEASE: begin
                            o_wr_addr      = wide_slot[IW-1:0];
                            o_wr.en        = slot_ok;
                            o_wr.period    = '0;
                            o_wr.remaining = '0;
                            n_st           = ST_DONE;
                            n_res_slot     = '0;
                            n_state        = S_EMIT;
                        end
                        K_SET: begin
                            o_wr_addr      = wide_slot[IW-1:0];
                            o_wr.en        = slot_ok;
                            o_wr.period    = i_period;
                            o_wr.remaining = i_period;
                            n_st           = ST_DONE;
                            n_res_slot     = '0;
                            n_state        = S_EMIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (!i_act) begin
                    o_wr.en        = 1'b1;
                    o_wr.period    = r_period;
                    o_wr.remaining = r_period;
                    n_st           = ST_GRANTED;
                    n_res_slot     = wide_idx[2:0];
                    n_state        = S_EMIT;
                end else if (last_idx) begin
                    n_st       = ST_REFUSED;
                    n_res_slot = '0;
                    n_state    = S_EMIT;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_TREAD: begin
                n_state = S_TEVAL;
            end
            S_TEVAL: begin
                if (report && r_pend_v) begin
                    o_res_valid = 1'b1;
                    o_res = '{status: ST_FIRED, slot_number: r_pend_slot,
                              time_now: r_tick, last: 1'b0};
                end
                if (!stall) begin
                    o_wr.en        = i_rd.active;
                    o_wr.period    = i_rd.period;
                    o_wr.remaining = fire ? i_rd.period : dec;
                    if (report) begin
                        n_pend_v    = 1'b1;
                        n_pend_slot = wide_idx[2:0];
                        n_cnt       = r_cnt + CW'(1);
                    end
                    if (last_idx) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_TREAD;
                    end
                end
            end
            S_FLUSH: begin
                o_res_valid = 1'b1;
                if (r_pend_v) begin
                    o_res = '{status: ST_FIRED, slot_number: r_pend_slot,
                              time_now: r_tick, last: 1'b1};
                end else begin
                    o_res = '{status: ST_DONE, slot_number: 3'd0,
                              time_now: r_tick, last: 1'b1};
                end
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_tick   <= '0;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_tick   <= n_tick;
            r_cnt    <= n_cnt;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_slot <= n_pend_slot;
        r_st        <= n_st;
        r_res_slot  <= n_res_slot;
        r_period    <= n_period;
    end

endmodule

// ----- sv/periodic_timer_slot_bank.sv -----
// Top level of the periodic timer slot bank: slot store, sequencer, result register.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_ready    i_kind, i_slot, i_period
//   result   out        o_valid / i_ready    o_status, o_slot_number, o_time_now, o_last
//
// A tick sweeps every slot through one decrement/compare unit, reading each slot
// from memory and then writing its update; a stalled result register holds the sweep.
// A request scans the active bits one slot a cycle. Release and set write the slot
// on acceptance. Synchronous active-low reset frees all slots.
// o_ready is high only between items.
module periodic_timer_slot_bank #(
    parameter int SLOT_COUNT = ptsb_pkg::SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_slot,
    input  logic [15:0] i_period,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [2:0]  o_slot_number,
    output logic [31:0] o_time_now,
    output logic        o_last
);
    import ptsb_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [IW-1:0] rd_addr;
    logic          act;
    t_slot_rd      rd;
    logic [IW-1:0] wr_addr;
    t_slot_wr      wr;
    logic          res_valid;
    logic          res_ready;
    t_result       res;

    logic          r_o_valid;
    t_result       r_o_res;

    ptsb_slot_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_act     (act),
        .o_rd      (rd),
        .i_wr_addr (wr_addr),
        .i_wr      (wr)
    );

    ptsb_seq #(.SLOT_COUNT(SLOT_COUNT)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_slot      (i_slot),
        .i_period    (i_period),
        .o_addr      (rd_addr),
        .i_act       (act),
        .i_rd        (rd),
        .o_wr_addr   (wr_addr),
        .o_wr        (wr),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res_ready) begin
            r_o_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_o_res <= res;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_res.status;
    assign o_slot_number = r_o_res.slot_number;
    assign o_time_now    = r_o_res.time_now;
    assign o_last        = r_o_res.last;

endmodule

// ----- tb/ptsb_result_checker.sv -----
// Result checker for the periodic timer slot bank: tracks slot state and compares results.
module ptsb_result_checker #(
    parameter int SLOT_COUNT = ptsb_pkg::SLOT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [2:0]  i_slot,
    input  logic [15:0] i_period,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [2:0]  i_slot_number,
    input  logic [31:0] i_time_now,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending_count
);
    import ptsb_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [PERIOD_W-1:0] slot_period    [SLOT_COUNT];
    logic [PERIOD_W-1:0] slot_remaining [SLOT_COUNT];
    logic [TIME_W-1:0]   tick_count;
    t_result             timer_results_q[$];
    int                  fail_total;

    initial begin
        o_fail_count    = 0;
        o_pending_count = 0;
        fail_total      = 0;
    end

    task automatic queue_result(input t_status status, input logic [2:0] slotno);
        t_result res;
        res.status      = status;
        res.slot_number = slotno;
        res.time_now    = tick_count;
        res.last        = 1'b0;
        timer_results_q.push_back(res);
    endtask

    // Apply one accepted item to the slot state and queue the results it causes.
    task automatic predict_timer_item(input logic [1:0] kind, input logic [2:0] slot,
                                      input logic [15:0] period);
        int      fired;
        int      pick;
        t_result tail;
        fired = 0;
        pick  = -1;
        case (kind)
            K_TICK: begin
                tick_count = tick_count + 1'b1;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (slot_period[i] != '0) begin
                        slot_remaining[i] = slot_remaining[i] - 1'b1;
                        if (slot_remaining[i] == '0) begin
                            slot_remaining[i] = slot_period[i];
                            if (fired < MAX_RESULTS) begin
                                queue_result(ST_FIRED, 3'(i));
                                fired++;
                            end
                        end
                    end
                end
                if (fired == 0) begin
                    queue_result(ST_DONE, 3'd0);
                end
            end
            K_REQUEST: begin
                if (period != '0) begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (pick < 0 && slot_period[i] == '0) begin
                            pick = i;
                        end
                    end
                end
                if (pick >= 0) begin
                    slot_period[pick]    = period;
                    slot_remaining[pick] = period;
                    queue_result(ST_GRANTED, 3'(pick));
                end else begin
                    queue_result(ST_REFUSED, 3'd0);
                end
            end
            K_RELEASE: begin
                if (int'(slot) < SLOT_COUNT) begin
                    slot_period[slot]    = '0;
                    slot_remaining[slot] = '0;
                end
                queue_result(ST_DONE, 3'd0);
            end
            default: begin
                if (int'(slot) < SLOT_COUNT) begin
                    slot_period[slot]    = period;
                    slot_remaining[slot] = period;
                end
                queue_result(ST_DONE, 3'd0);
            end
        endcase
        tail      = timer_results_q.pop_back();
        tail.last = 1'b1;
        timer_results_q.push_back(tail);
    endtask

    task automatic check_result();
        t_result want;
        if (timer_results_q.size() == 0) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT) begin
                $display("unexpected result: exp none, got status %0d slot %0d time %0d last %0d",
                         i_status, i_slot_number, i_time_now, i_last);
            end
        end else begin
            want = timer_results_q.pop_front();
            if (want.status != t_status'(i_status) || want.slot_number != i_slot_number ||
                want.time_now != i_time_now || want.last != i_last) begin
                fail_total++;
                if (fail_total <= REPORT_LIMIT) begin
                    $display("result mismatch: exp status %0d slot %0d time %0d last %0d",
                             want.status, want.slot_number, want.time_now, want.last);
                    $display("                 got status %0d slot %0d time %0d last %0d",
                             i_status, i_slot_number, i_time_now, i_last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_period[i]    = '0;
                slot_remaining[i] = '0;
            end
            tick_count = '0;
            timer_results_q.delete();
        end else begin
            // input side first: its results cannot leave in the same cycle
            if (i_in_valid && i_in_ready) begin
                predict_timer_item(i_kind, i_slot, i_period);
            end
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
        end
        o_pending_count <= timer_results_q.size();
        o_fail_count    <= fail_total;
    end

endmodule

// ----- tb/tb_periodic_timer_slot_bank.sv -----
// Testbench top for the periodic timer slot bank: clock, reset, stimulus and verdict.
module tb_periodic_timer_slot_bank;
    import ptsb_pkg::*;

    localparam int RANDOM_ITEMS   = 385;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 64;

    // receiver behavior
    localparam logic [1:0] RX_STEADY = 2'd0;
    localparam logic [1:0] RX_CHOPPY = 2'd1;
    localparam logic [1:0] RX_BURSTY = 2'd2;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_kind;
    logic [2:0]  i_slot;
    logic [15:0] i_period;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [2:0]  o_slot_number;
    logic [31:0] o_time_now;
    logic        o_last;

    int          fail_count;
    int          pending_count;
    int          burst_left;
    int          quiet_cycles;
    logic [1:0]  rx_mode;
    logic [6:0]  rx_cycle;
    int          rx_stall_left;

    periodic_timer_slot_bank DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_slot        (i_slot),
        .i_period      (i_period),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_slot_number (o_slot_number),
        .o_time_now    (o_time_now),
        .o_last        (o_last)
    );

    ptsb_result_checker result_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_kind          (i_kind),
        .i_slot          (i_slot),
        .i_period        (i_period),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_status        (o_status),
        .i_slot_number   (o_slot_number),
        .i_time_now      (o_time_now),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always #1 i_clk = ~i_clk;

    // receiver: steady, coin-flip, or mostly ready with occasional long stalls
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        if (rx_cycle == '0) begin
            rx_mode <= 2'($urandom_range(0, 2));
        end
        if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            i_ready       <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STEADY: i_ready <= 1'b1;
                RX_CHOPPY: i_ready <= 1'($urandom_range(0, 1));
                RX_BURSTY: begin
                    if ($urandom_range(0, 15) == 0) begin
                        rx_stall_left <= $urandom_range(4, 30);
                        i_ready       <= 1'b0;
                    end else begin
                        i_ready <= 1'b1;
                    end
                end
                default: i_ready <= 1'b1;
            endcase
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one item; valid stays up across back-to-back transfers.
    task automatic send_item(input logic [1:0] kind, input logic [2:0] slot,
                             input logic [15:0] period);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_valid  <= 1'b1;
        i_kind   <= kind;
        i_slot   <= slot;
        i_period <= period;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
    endtask

    // Hold the sender until every outstanding result has been taken.
    task automatic drain_results();
        i_valid    <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    function automatic logic [15:0] pick_period();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return 16'h0000;
            1:       return 16'($urandom);
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    initial begin
        int sel;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_kind        = K_TICK;
        i_slot        = 3'd0;
        i_period      = 16'h0000;
        i_ready       = 1'b0;
        rx_mode       = RX_STEADY;
        rx_cycle      = '0;
        rx_stall_left = 0;
        quiet_cycles  = 0;
        burst_left    = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty bank, zero-period request, fill to full, refusal on full bank
        send_item(K_TICK, 3'd0, 16'h0000);
        send_item(K_REQUEST, 3'd0, 16'h0000);
        send_item(K_REQUEST, 3'd7, 16'h0001);
        send_item(K_REQUEST, 3'd0, 16'hFFFF);
        send_item(K_REQUEST, 3'd0, 16'h0002);
        for (int i = 0; i < 5; i++) begin
            send_item(K_REQUEST, 3'd0, 16'h0001);
        end
        send_item(K_REQUEST, 3'd0, 16'h0005);
        send_item(K_TICK, 3'd0, 16'h0000);
        send_item(K_TICK, 3'd0, 16'h0000);
        // every slot fires on one tick
        send_item(K_SET, 3'd1, 16'h0001);
        send_item(K_SET, 3'd2, 16'h0001);
        send_item(K_TICK, 3'd0, 16'h0000);
        // release, release of a free slot, set to zero, set on a free slot
        send_item(K_RELEASE, 3'd4, 16'h0000);
        send_item(K_RELEASE, 3'd4, 16'h0000);
        send_item(K_SET, 3'd5, 16'h0000);
        send_item(K_SET, 3'd4, 16'h8000);
        send_item(K_REQUEST, 3'd0, 16'h5555);
        send_item(K_RELEASE, 3'd7, 16'hFFFF);
        send_item(K_SET, 3'd7, 16'hAAAA);
        send_item(K_TICK, 3'd7, 16'hFFFF);
        send_item(K_TICK, 3'd0, 16'h0000);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3) begin
                drain_results();
            end
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                send_item(K_TICK, 3'($urandom_range(0, 7)), 16'($urandom));
            end else if (sel < 68) begin
                send_item(K_REQUEST, 3'($urandom_range(0, 7)), pick_period());
            end else if (sel < 84) begin
                send_item(K_RELEASE, 3'($urandom_range(0, 7)), 16'($urandom));
            end else begin
                send_item(K_SET, 3'($urandom_range(0, 7)), pick_period());
            end
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
